@@ hdl/sorted_list_insert_delete_core_defines.svh @@
// Assertion macros used by the sorted list datapath.
`ifndef SORTED_LIST_INSERT_DELETE_CORE_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SLI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted list core: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted list core: next-cycle check failed");

`endif

@@ hdl/sli_pkg.sv @@
// Types, constants and codes shared by the sorted list core.
`timescale 1ns / 1ps
package sli_pkg;

  localparam int CAPACITY = 8;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int PTR_W    = $clog2(CAPACITY);
  localparam int CMP_W    = (CNT_W > 3) ? CNT_W : 3;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
    logic [2:0]         index;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         count;
    logic [1:0]         status;
    logic signed [31:0] read_value;
  } out_item_t;

  typedef struct packed {
    logic       load_in;
    logic       ptr_inc;
    logic       set_status;
    logic [1:0] status_code;
    logic       capture_rd;
    logic       apply_ins;
    logic       apply_del;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       at_end;
    logic       full;
    logic       le;
    logic       eq;
    logic       idx_fits;
  } dp_stat_t;

endpackage

@@ hdl/sli_ctrl.sv @@
// Controller state machine that sequences scan, shift and result delivery.
`timescale 1ns / 1ps
module sli_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_free_i,
  input  sli_pkg::dp_stat_t dp_stat_i,
  output logic              in_stall_o,
  output logic              load_out_o,
  output sli_pkg::dp_cmd_t  dp_cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_APPLY  = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    dp_cmd_o   = '0;
    load_out_o = 1'b0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          dp_cmd_o.load_in = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        unique case (dp_stat_i.command)
          sli_pkg::CMD_INSERT: begin
            if (dp_stat_i.full) begin
              dp_cmd_o.set_status  = 1'b1;
              dp_cmd_o.status_code = sli_pkg::ST_FULL;
              state_d              = S_RESULT;
            end else if (!dp_stat_i.at_end && dp_stat_i.le) begin
              dp_cmd_o.ptr_inc = 1'b1;
            end else begin
              state_d = S_APPLY;
            end
          end
          sli_pkg::CMD_DELETE: begin
            if (dp_stat_i.at_end) begin
              dp_cmd_o.set_status  = 1'b1;
              dp_cmd_o.status_code = sli_pkg::ST_NOT_FOUND;
              state_d              = S_RESULT;
            end else if (dp_stat_i.eq) begin
              state_d = S_APPLY;
            end else begin
              dp_cmd_o.ptr_inc = 1'b1;
            end
          end
          sli_pkg::CMD_READ: begin
            if (dp_stat_i.idx_fits) begin
              dp_cmd_o.capture_rd = 1'b1;
            end else begin
              dp_cmd_o.set_status  = 1'b1;
              dp_cmd_o.status_code = sli_pkg::ST_BAD_INDEX;
            end
            state_d = S_RESULT;
          end
          default: begin
            state_d = S_RESULT;
          end
        endcase
      end
      S_APPLY: begin
        if (dp_stat_i.command == sli_pkg::CMD_INSERT) begin
          dp_cmd_o.apply_ins = 1'b1;
        end else begin
          dp_cmd_o.apply_del = 1'b1;
        end
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (out_free_i) begin
          load_out_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/sli_datapath.sv @@
// Datapath with the entry lanes, scan pointer, entry count and result fields.
`timescale 1ns / 1ps
`include "sorted_list_insert_delete_core_defines.svh"
module sli_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sli_pkg::dp_cmd_t   dp_cmd_i,
  input  sli_pkg::in_item_t  in_item_i,
  output sli_pkg::dp_stat_t  dp_stat_o,
  output sli_pkg::out_item_t result_o
);

  logic [1:0]                  cmd_q;
  logic signed [31:0]          value_q;
  logic                        idx_fits_q;
  logic [sli_pkg::CNT_W-1:0]   ptr_q;
  logic [sli_pkg::CNT_W-1:0]   count_q;
  logic [1:0]                  status_q;
  logic signed [31:0]          rd_q;
  logic signed [31:0]          entries_q [sli_pkg::CAPACITY];
  logic signed [31:0]          lower_w   [sli_pkg::CAPACITY];
  logic signed [31:0]          upper_w   [sli_pkg::CAPACITY];
  logic signed [31:0]          cur_w;
  logic [sli_pkg::CMP_W-1:0]   idx_ext;
  logic [sli_pkg::CMP_W-1:0]   count_ext;
  logic [sli_pkg::CNT_W+3:0]   count_wide;

  assign idx_ext   = sli_pkg::CMP_W'(in_item_i.index);
  assign count_ext = sli_pkg::CMP_W'(count_q);
  assign cur_w     = entries_q[ptr_q[sli_pkg::PTR_W-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (dp_cmd_i.apply_ins) begin
      count_q <= count_q + 1'b1;
    end else if (dp_cmd_i.apply_del) begin
      count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load_in) begin
      cmd_q      <= in_item_i.command;
      value_q    <= in_item_i.value;
      idx_fits_q <= idx_ext < count_ext;
      ptr_q      <= (in_item_i.command == sli_pkg::CMD_READ) ?
                    idx_ext[sli_pkg::CNT_W-1:0] : '0;
      status_q   <= sli_pkg::ST_OK;
      rd_q       <= '0;
    end else begin
      if (dp_cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + 1'b1;
      end
      if (dp_cmd_i.set_status) begin
        status_q <= dp_cmd_i.status_code;
      end
      if (dp_cmd_i.capture_rd) begin
        rd_q <= cur_w;
      end
    end
  end

  for (genvar k = 0; k < sli_pkg::CAPACITY; k++) begin : g_lane
    localparam logic [sli_pkg::CNT_W-1:0] LANE     = sli_pkg::CNT_W'(k);
    localparam logic [sli_pkg::CNT_W-1:0] LANE_NXT = sli_pkg::CNT_W'(k + 1);

    if (k == 0) begin : g_first
      assign lower_w[k] = '0;
    end else begin : g_rest
      assign lower_w[k] = entries_q[k-1];
    end

    if (k == sli_pkg::CAPACITY - 1) begin : g_last
      assign upper_w[k] = '0;
    end else begin : g_inner
      assign upper_w[k] = entries_q[k+1];
    end

    always_ff @(posedge clk_i) begin
      if (dp_cmd_i.apply_ins) begin
        if (LANE == ptr_q) begin
          entries_q[k] <= value_q;
        end else if ((LANE > ptr_q) && (LANE <= count_q)) begin
          entries_q[k] <= lower_w[k];
        end
      end else if (dp_cmd_i.apply_del) begin
        if ((LANE >= ptr_q) && (LANE_NXT < count_q)) begin
          entries_q[k] <= upper_w[k];
        end
      end
    end
  end

  assign dp_stat_o.command  = cmd_q;
  assign dp_stat_o.at_end   = ptr_q >= count_q;
  assign dp_stat_o.full     = count_q >= sli_pkg::CNT_W'(sli_pkg::CAPACITY);
  assign dp_stat_o.le       = cur_w <= value_q;
  assign dp_stat_o.eq       = cur_w == value_q;
  assign dp_stat_o.idx_fits = idx_fits_q;

  assign count_wide          = {4'b0000, count_q};
  assign result_o.count      = count_wide[3:0];
  assign result_o.status     = status_q;
  assign result_o.read_value = rd_q;

  `SLI_ASSERT_NOW(a_count_range, clk_i, rst_ni, 1'b1, count_q <= sli_pkg::CNT_W'(sli_pkg::CAPACITY))
  `SLI_ASSERT_NOW(a_ins_room, clk_i, rst_ni, dp_cmd_i.apply_ins, !dp_stat_o.full && (ptr_q <= count_q))
  `SLI_ASSERT_NOW(a_del_hit, clk_i, rst_ni, dp_cmd_i.apply_del, (ptr_q < count_q) && dp_stat_o.eq)
  `SLI_ASSERT_NEXT(a_ins_grows, clk_i, rst_ni, dp_cmd_i.apply_ins, count_q == sli_pkg::CNT_W'($past(count_q) + 1'b1))

endmodule

@@ hdl/sorted_list_insert_delete_core.sv @@
// Sorted list of signed 32-bit values: insert, delete and indexed read.
//
// The input channel carries one command per transaction: insert a value,
// delete the first equal value, or read the entry at an index. Every accepted
// transaction yields exactly one result transaction with the entry count after
// the command, a status code and, for a good read, the entry value.
// A command is taken only while the block is idle; in_stall_o is high from
// acceptance until the result has moved into the output register.
// The scan walks one entry per cycle; an insert with room or a delete that
// finds its value then shifts the entries in the apply state, while a read
// takes the entry at its index in the scan state. The shift moves all
// entry lanes together. The next command is accepted in the cycle after
// the result is registered, so commands are taken one at a time.
// A stalled result holds in the output register; the block then finishes
// the next command and waits with it until the register frees up.
// Reset empties the list and drops any pending result.
`timescale 1ns / 1ps
module sorted_list_insert_delete_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sli_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sli_pkg::out_item_t out_item_o
);

  sli_pkg::dp_cmd_t   dp_cmd;
  sli_pkg::dp_stat_t  dp_stat;
  sli_pkg::out_item_t result;
  logic               load_out;
  logic               out_free;
  logic               out_valid_q;
  sli_pkg::out_item_t out_item_q;

  assign out_free = !out_valid_q || !out_stall_i;

  sli_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .dp_stat_i  (dp_stat),
    .in_stall_o (in_stall_o),
    .load_out_o (load_out),
    .dp_cmd_o   (dp_cmd)
  );

  sli_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .dp_cmd_i  (dp_cmd),
    .in_item_i (in_item_i),
    .dp_stat_o (dp_stat),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
